// ===== sv/rwc_pkg.sv =====
// ----------------------------------------------------------------------------
// rwc_pkg - shared types and constants for the replay window check
// Request layouts, status codes and the command layout of the serial
// remainder unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rwc_pkg;

    localparam int SEQ_W                = 32;
    localparam int CFG_W                = 7;
    localparam int STATUS_W             = 3;
    localparam int BYTE_W               = 8;
    localparam int BIT_SEL_W            = 3;
    localparam int DIVD_W               = SEQ_W - BIT_SEL_W;
    localparam int MAX_WINDOW_BYTES_DEF = 64;

    localparam logic [CFG_W-1:0]  WINDOW_RESET  = 7'd16;
    localparam logic [BYTE_W-1:0] BYTE_ALL_ONES = 8'hFF;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_IN_ORDER  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_GAP_FILL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RESYNC    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LATE_FILL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FAR_DROP  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LATE_DROP = 3'd5;

    typedef struct packed {
        logic             action;
        logic [SEQ_W-1:0] seq_num;
    } t_in_req;

    typedef struct packed {
        logic                accepted;
        logic [STATUS_W-1:0] status;
        logic [SEQ_W-1:0]    lost_count;
        logic [SEQ_W-1:0]    expected_next;
        logic [SEQ_W-1:0]    received_count;
    } t_out_req;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
    } t_mod_cmd;

endpackage

`default_nettype wire

// ===== sv/replay_window_check.sv =====
// ----------------------------------------------------------------------------
// replay_window_check - anti-replay sliding window check
// Checks (and optionally commits) packet sequence numbers against an
// expected number and a circular bitmap of outstanding late numbers.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                 payload
//  -------   ---  ------------------------  ---------------------------------
//  in        in   i_in_valid / o_in_stall   i_in_data  (action, seq_num)
//  out       out  o_out_valid / i_out_stall o_out_data (accepted, status, ...)
//  cfg       in   i_cfg_we                  i_cfg_data (window_bytes)
//
//  One request at a time; a disabled window skips the bitmap. Late or
//  committed requests not dropped at once run the 29-step serial remainder
//  for their bitmap byte. First, a committed resync fills all w bytes, and
//  a committed gap fill does a remainder run, then up to w+1 byte updates.
//  Reset (sync, active low) clears counters, FSM and the bitmap valid bits;
//  an unwritten bitmap byte reads as zero. A result waiting on i_out_stall
//  holds in the output register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module replay_window_check
    import rwc_pkg::*;
#(
    parameter int MAX_WINDOW_BYTES = MAX_WINDOW_BYTES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_req          i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_req              o_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int WIN_W = $clog2(MAX_WINDOW_BYTES + 1);
    localparam int IDX_W = (MAX_WINDOW_BYTES > 1) ? $clog2(MAX_WINDOW_BYTES) : 1;
    localparam int CMP_W = (WIN_W > CFG_W) ? WIN_W : CFG_W;

    // FSM codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLASS  = 4'd1;
    localparam logic [3:0] S_FILL   = 4'd2;
    localparam logic [3:0] S_GSTART = 4'd3;
    localparam logic [3:0] S_GWAIT  = 4'd4;
    localparam logic [3:0] S_GRD    = 4'd5;
    localparam logic [3:0] S_GWR    = 4'd6;
    localparam logic [3:0] S_SSTART = 4'd7;
    localparam logic [3:0] S_SWAIT  = 4'd8;
    localparam logic [3:0] S_SRD    = 4'd9;
    localparam logic [3:0] S_SWR    = 4'd10;
    localparam logic [3:0] S_FIN    = 4'd11;

    // ------------------------------------------------------------------
    // Config register and active window (clamped to the bitmap size)
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_window_bytes;
    logic [CMP_W-1:0] win_ext;
    logic [CMP_W-1:0] max_ext;
    logic [WIN_W-1:0] act_w;
    logic [SEQ_W-1:0] span32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_bytes <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window_bytes <= i_cfg_data;
        end
    end

    always_comb begin
        win_ext = CMP_W'(r_window_bytes);
        max_ext = CMP_W'(MAX_WINDOW_BYTES);
        act_w   = (win_ext > max_ext) ? max_ext[WIN_W-1:0] : win_ext[WIN_W-1:0];
        span32  = SEQ_W'({act_w, 3'b000});
    end

    // ------------------------------------------------------------------
    // Architectural state
    // ------------------------------------------------------------------
    logic [SEQ_W-1:0] r_exp;     // next expected sequence number
    logic [SEQ_W-1:0] r_far;     // far-ahead run length
    logic [SEQ_W-1:0] r_rcv;     // received count

    logic [3:0] r_state;
    logic [3:0] n_state;

    // per-request registers
    logic                r_commit;
    logic [SEQ_W-1:0]    r_seq;
    logic [SEQ_W-1:0]    r_seqm1;
    logic [WIN_W-1:0]    r_w;
    logic [SEQ_W-1:0]    r_span;
    logic [SEQ_W-1:0]    r_hi;
    logic [SEQ_W-1:0]    r_lo;
    logic                r_ok;
    logic [STATUS_W-1:0] r_status;
    logic [SEQ_W-1:0]    r_lost;
    logic                r_late;
    logic                r_clear;
    logic                r_ge;
    logic [IDX_W-1:0]    r_idx;
    logic [SEQ_W-1:0]    r_cur;

    logic in_acc;
    assign in_acc     = i_in_valid && !o_in_stall;
    // held off while in reset, so nothing is taken that reset would drop
    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;

    // ------------------------------------------------------------------
    // Bitmap memory: one byte per entry, registered read.
    // Valid bits give the reset value (zero) for bytes never written.
    // A read never shares a cycle with a write to the same byte; it always
    // comes in a later cycle, so no bypass is needed.
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] r_mem [MAX_WINDOW_BYTES];
    logic [MAX_WINDOW_BYTES-1:0] r_vld;
    logic [BYTE_W-1:0] r_rd_data;
    logic              r_rd_vld;
    logic              mem_we;
    logic              mem_re;
    logic [BYTE_W-1:0] mem_wdata;
    logic [BYTE_W-1:0] rd_byte;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_idx];
            r_rd_vld  <= r_vld[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (mem_we) begin
            r_vld[r_idx] <= 1'b1;
        end
    end

    assign rd_byte = r_rd_vld ? r_rd_data : '0;

    // ------------------------------------------------------------------
    // Serial remainder: byte index = (n / 8) mod w
    // ------------------------------------------------------------------
    t_mod_cmd         mod_cmd;
    logic             mod_done;
    logic [IDX_W-1:0] mod_rem;

    always_comb begin
        mod_cmd.start    = (r_state == S_GSTART) || (r_state == S_SSTART);
        mod_cmd.dividend = (r_state == S_GSTART) ? r_exp[SEQ_W-1:BIT_SEL_W]
                                                 : r_seq[SEQ_W-1:BIT_SEL_W];
    end

    rwc_mod #(
        .MAX_WINDOW_BYTES(MAX_WINDOW_BYTES)
    ) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (mod_cmd),
        .i_divisor (r_w),
        .o_done    (mod_done),
        .o_rem     (mod_rem)
    );

    // ------------------------------------------------------------------
    // Classification (CLASS state, from registered request)
    // ------------------------------------------------------------------
    logic                c_eq, c_far, c_lt, c_old, c_drop_far, c_wzero;
    logic                c_ok, c_fill, c_gap, c_late, c_clear;
    logic [STATUS_W-1:0] c_status;
    logic [SEQ_W-1:0]    c_lost;

    always_comb begin
        c_wzero    = (r_w == '0);
        c_eq       = (r_seq == r_exp);
        c_far      = (r_seq >= r_hi);
        c_lt       = (r_seq < r_exp);
        c_old      = (r_exp >= r_span) && (r_seq < r_lo);
        c_drop_far = (r_far < SEQ_W'(r_w >> 2));
        c_ok       = 1'b1;
        c_fill     = 1'b0;
        c_gap      = 1'b0;
        c_late     = 1'b0;
        c_clear    = 1'b0;
        c_status   = ST_IN_ORDER;
        c_lost     = '0;
        if (c_wzero) begin
            // checking disabled: everything passes
            if (c_eq) begin
                c_status = ST_IN_ORDER;
            end else if (c_lt) begin
                c_status = ST_LATE_FILL;
            end else begin
                c_status = ST_GAP_FILL;
            end
        end else if (c_eq) begin
            c_clear = r_commit;
        end else if (c_far) begin
            if (c_drop_far) begin
                c_ok     = 1'b0;
                c_status = ST_FAR_DROP;
            end else begin
                c_status = ST_RESYNC;
                c_lost   = r_seq - r_exp;
                c_fill   = r_commit;
                c_clear  = r_commit;
            end
        end else if (c_lt) begin
            if (c_old) begin
                c_ok     = 1'b0;
                c_status = ST_LATE_DROP;
            end else begin
                // final verdict waits on the bitmap bit
                c_status = ST_LATE_FILL;
                c_late   = 1'b1;
                c_clear  = r_commit;
            end
        end else begin
            c_status = ST_GAP_FILL;
            c_gap    = r_commit;
            c_clear  = r_commit;
        end
    end

    // ------------------------------------------------------------------
    // Gap walk: one bitmap byte per read/write pair, bits [exp, seq)
    // ------------------------------------------------------------------
    logic [BIT_SEL_W-1:0] g_lo;
    logic [BIT_SEL_W-1:0] g_hi;
    logic                 g_last;
    logic [BYTE_W-1:0]    g_mask;
    logic                 idx_last;
    logic [WIN_W-1:0]     w_last;
    logic [IDX_W-1:0]     idx_next;
    logic [BYTE_W-1:0]    seq_bit;
    logic                 bit_set;
    logic                 swr_write;

    always_comb begin
        g_lo     = r_cur[BIT_SEL_W-1:0];
        g_last   = (r_cur[SEQ_W-1:BIT_SEL_W] == r_seqm1[SEQ_W-1:BIT_SEL_W]);
        g_hi     = g_last ? r_seqm1[BIT_SEL_W-1:0] : 3'd7;
        g_mask   = (BYTE_ALL_ONES << g_lo) & (BYTE_ALL_ONES >> (3'd7 - g_hi));
        w_last   = r_w - WIN_W'(1);
        idx_last = (WIN_W'(r_idx) == w_last);
        idx_next = idx_last ? '0 : (r_idx + IDX_W'(1));
        seq_bit  = BYTE_W'(1) << r_seq[BIT_SEL_W-1:0];
        bit_set  = |(rd_byte & seq_bit);
        // a late number whose flag is clear is a replay: no write
        swr_write = r_clear && !(r_late && !bit_set);
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic fin_go;
    assign fin_go = (r_state == S_FIN) && (!o_out_valid || !i_out_stall);

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_CLASS;
            end
            S_CLASS: begin
                if (c_fill) begin
                    n_state = S_FILL;
                end else if (c_gap) begin
                    n_state = S_GSTART;
                end else if (c_late || c_clear) begin
                    n_state = S_SSTART;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = BYTE_ALL_ONES;
                if (idx_last) n_state = S_SSTART;
            end
            S_GSTART: begin
                n_state = S_GWAIT;
            end
            S_GWAIT: begin
                if (mod_done) n_state = S_GRD;
            end
            S_GRD: begin
                mem_re  = 1'b1;
                n_state = S_GWR;
            end
            S_GWR: begin
                mem_we    = 1'b1;
                mem_wdata = rd_byte | g_mask;
                n_state   = g_last ? S_SSTART : S_GRD;
            end
            S_SSTART: begin
                n_state = S_SWAIT;
            end
            S_SWAIT: begin
                if (mod_done) n_state = S_SRD;
            end
            S_SRD: begin
                mem_re  = 1'b1;
                n_state = S_SWR;
            end
            S_SWR: begin
                mem_we    = swr_write;
                mem_wdata = rd_byte & ~seq_bit;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (fin_go) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // per-request datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_commit <= i_in_data.action;
                    r_seq    <= i_in_data.seq_num;
                    r_w      <= act_w;
                    r_span   <= span32;
                    r_hi     <= r_exp + span32;
                    r_lo     <= r_exp - span32;
                end
            end
            S_CLASS: begin
                r_ok     <= c_ok;
                r_status <= c_status;
                r_lost   <= c_lost;
                r_late   <= c_late;
                r_clear  <= c_clear;
                r_ge     <= !c_lt;
                r_seqm1  <= r_seq - SEQ_W'(1);
                r_idx    <= '0;
                r_cur    <= r_exp;
            end
            S_FILL: begin
                r_idx <= idx_next;
            end
            S_GWAIT, S_SWAIT: begin
                if (mod_done) r_idx <= mod_rem;
            end
            S_GWR: begin
                r_idx <= idx_next;
                r_cur <= {r_cur[SEQ_W-1:BIT_SEL_W] + DIVD_W'(1), 3'b000};
            end
            S_SWR: begin
                if (r_late && !bit_set) begin
                    r_ok     <= 1'b0;
                    r_status <= ST_LATE_DROP;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Commit and result
    // ------------------------------------------------------------------
    logic             upd;
    logic [SEQ_W-1:0] n_exp;
    logic [SEQ_W-1:0] n_rcv;
    logic [SEQ_W-1:0] n_far;

    always_comb begin
        upd   = r_ok && r_commit;
        n_exp = (upd && r_ge) ? (r_seq + SEQ_W'(1)) : r_exp;
        n_rcv = r_rcv;
        if (upd) begin
            n_rcv = (n_exp == '0) ? '0 : (r_rcv + SEQ_W'(1));
        end
        n_far = r_far;
        if (r_commit && (r_w != '0)) begin
            if (r_ok) begin
                n_far = '0;
            end else if (r_status == ST_FAR_DROP) begin
                n_far = r_far + SEQ_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0;
            r_far <= '0;
            r_rcv <= '0;
        end else if (fin_go) begin
            r_exp <= n_exp;
            r_far <= n_far;
            r_rcv <= n_rcv;
        end
    end

    // output register: decouples the next request from a stalled result
    logic     r_out_valid;
    t_out_req r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out.accepted       <= r_ok;
            r_out.status         <= r_status;
            r_out.lost_count     <= r_lost;
            r_out.expected_next  <= n_exp;
            r_out.received_count <= n_rcv;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result appeared without passing the finish state");

    a_mod_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> ((r_state == S_GWAIT) || (r_state == S_SWAIT)))
        else $error("remainder finished while nobody was waiting");

    a_gap_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GWR) |->
            (r_cur[SEQ_W-1:BIT_SEL_W] <= r_seqm1[SEQ_W-1:BIT_SEL_W]))
        else $error("gap walk ran past the received number");

    a_status_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.accepted ==
            !((o_out_data.status == ST_FAR_DROP) || (o_out_data.status == ST_LATE_DROP))))
        else $error("accepted flag disagrees with status");

endmodule

`default_nettype wire

// ===== sv/rwc_mod.sv =====
// ----------------------------------------------------------------------------
// rwc_mod - serial remainder unit
// Computes dividend mod divisor, one dividend bit per cycle (restoring).
// ----------------------------------------------------------------------------
`default_nettype none

module rwc_mod
    import rwc_pkg::*;
#(
    parameter int MAX_WINDOW_BYTES = MAX_WINDOW_BYTES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_mod_cmd                     i_cmd,
    input  wire logic [$clog2(MAX_WINDOW_BYTES+1)-1:0] i_divisor,
    output logic                              o_done,
    output logic [((MAX_WINDOW_BYTES > 1) ? $clog2(MAX_WINDOW_BYTES) : 1)-1:0] o_rem
);

    localparam int WIN_W = $clog2(MAX_WINDOW_BYTES + 1);
    localparam int IDX_W = (MAX_WINDOW_BYTES > 1) ? $clog2(MAX_WINDOW_BYTES) : 1;
    localparam int CNT_W = $clog2(DIVD_W + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVD_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVD_W-1:0] r_divd;
    logic [WIN_W-1:0]  r_rem;
    logic [WIN_W-1:0]  r_dsor;

    logic [WIN_W:0]    trial;
    logic [WIN_W:0]    diff;
    logic [WIN_W-1:0]  n_rem;

    // one restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_divd[DIVD_W-1]};
        diff  = trial - {1'b0, r_dsor};
        n_rem = (trial >= {1'b0, r_dsor}) ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_LAST)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cnt  <= '0;
            r_divd <= i_cmd.dividend;
            r_rem  <= '0;
            r_dsor <= i_divisor;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + CNT_W'(1);
            r_divd <= {r_divd[DIVD_W-2:0], 1'b0};
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[IDX_W-1:0];

endmodule

`default_nettype wire
